// File: src/tbps_pkg.sv
// Shared types, codes and constants of the token bucket packet shaper.
// No dependencies; every other file refers to it by scoped names.
package tbps_pkg;

   localparam int FRACTION_BITS_DEFAULT = 8;

   localparam int LEN_W      = 16;
   localparam int RATE_W     = 32;
   localparam int TOKEN_W    = 40;
   localparam int CSR_DATA_W = 40;

   localparam logic [RATE_W-1:0]  RATE_RESET  = 32'd256;
   localparam logic [TOKEN_W-1:0] DEPTH_RESET = 40'd268435456;

   // Operation codes of an input word
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_PACKET = 1'b1;

   // Register indexes of the configuration port
   localparam logic CSR_RATE  = 1'b0;
   localparam logic CSR_DEPTH = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_RELEASED = 2'd0;
   localparam logic [1:0] ST_HELD     = 2'd1;
   localparam logic [1:0] ST_DROPPED  = 2'd2;
   localparam logic [1:0] ST_BUSY     = 2'd3;

   typedef struct packed {
      logic             operation;
      logic [LEN_W-1:0] packet_length;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [LEN_W-1:0]   packet_length_out;
      logic [TOKEN_W-1:0] tokens_left;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      logic       push;
      logic       pop;
   } queue_status_type;

   typedef struct packed {
      logic held_valid;
      logic emit;
   } back_status_type;

endpackage

// File: src/token_bucket_packet_shaper.sv
// Top level of the token bucket packet shaper: front end, queue and token engine.
// Depends on tbps_pkg, tbps_front, tbps_queue and tbps_back.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  tbps_pkg::req_type (operation, packet_length)
//   rsp      out        rsp_valid/rsp_stall  tbps_pkg::rsp_type (status, length, tokens)
//   csr      in         csr_write            csr_index (1 bit), csr_data (40 bits)
//
// One word per cycle sustained while the queue has room and no result stalls; a word
// with a result goes to a queue slot at the accepting edge, then to the result register.
// The token engine does one add, clamp, compare and subtract per cycle, unless stalled,
// against its own token count.
// Reset is synchronous: count, hold and queue clear, rate and depth load defaults.
// req_stall rises only when the two-entry queue is full; a stalled valid rsp holds
// the result register and stops the engine, while the queue still fills to two words.
module token_bucket_packet_shaper #(
   parameter int FRACTION_BITS = tbps_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tbps_pkg::req_type               req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tbps_pkg::rsp_type               rsp_word,
   input  logic                            csr_write,
   input  logic                            csr_index,
   input  logic [tbps_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int COST_W  = tbps_pkg::LEN_W + 3 + FRACTION_BITS;
   localparam int ENTRY_W = 2 + tbps_pkg::LEN_W + COST_W;

   logic [ENTRY_W-1:0]          front_entry;
   logic [ENTRY_W-1:0]          head_data;
   logic                        head_valid;
   logic                        queue_full;
   logic                        pop;
   logic [tbps_pkg::TOKEN_W-1:0] bucket_depth;
   tbps_pkg::queue_status_type  queue_status;
   tbps_pkg::back_status_type   back_status;

   // Decode the word and precompute its cost in token units
   tbps_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .req_word     (req_word),
      .bucket_depth (bucket_depth),
      .entry        (front_entry)
   );

   // Decouple acceptance from the token engine
   tbps_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_data  (front_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .status     (queue_status)
   );

   assign req_stall = queue_full;

   // Apply ticks and packets to the bucket, hold the result for the consumer
   tbps_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .head_valid   (head_valid),
      .head_data    (head_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .bucket_depth (bucket_depth),
      .status       (back_status)
   );

   // A held or busy result only shows while a packet sits in the hold
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == tbps_pkg::ST_HELD ||
                    rsp_word.status == tbps_pkg::ST_BUSY) |-> back_status.held_valid)
      else $error("held or busy result without a held packet");

   // A pop without a push drains exactly one queue entry
   assert property (@(posedge clock) disable iff (reset)
      queue_status.pop && !queue_status.push |=>
         queue_status.count == $past(queue_status.count) - 2'd1)
      else $error("queue count out of step with pops");

   // The engine only emits into a free or draining result register
   assert property (@(posedge clock) disable iff (reset)
      back_status.emit |-> !rsp_valid || !rsp_stall)
      else $error("result emitted over a stalled result");

endmodule

// File: src/tbps_front.sv
// Front end of the shaper: decode an input word and precompute its cost.
// Depends on tbps_pkg.
module tbps_front #(
   parameter int FRACTION_BITS = tbps_pkg::FRACTION_BITS_DEFAULT,
   localparam int COST_W  = tbps_pkg::LEN_W + 3 + FRACTION_BITS,
   localparam int ENTRY_W = 2 + tbps_pkg::LEN_W + COST_W
) (
   input  tbps_pkg::req_type              req_word,
   input  logic [tbps_pkg::TOKEN_W-1:0]   bucket_depth,
   output logic [ENTRY_W-1:0]             entry
);

   logic [COST_W-1:0] cost;
   logic              oversize;

   // cost in token units: length in bytes, times 8 bits, times the fraction scale
   assign cost     = {req_word.packet_length, (3 + FRACTION_BITS)'(0)};
   assign oversize = tbps_pkg::TOKEN_W'(cost) > bucket_depth;

   assign entry = {req_word.operation, oversize, req_word.packet_length, cost};

endmodule

// File: src/tbps_queue.sv
// Two-entry queue between the front end and the token engine.
// Depends on tbps_pkg for its status struct.
module tbps_queue #(
   parameter int WIDTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       full,
   output logic                       head_valid,
   output logic [WIDTH-1:0]           head_data,
   input  logic                       pop,
   output tbps_pkg::queue_status_type status
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign status = '{count: count_ff, push: do_push, pop: do_pop};

endmodule

// File: src/tbps_back.sv
// Token engine: configuration registers, token count, held packet and result register.
// Depends on tbps_pkg.
module tbps_back #(
   parameter int FRACTION_BITS = tbps_pkg::FRACTION_BITS_DEFAULT,
   localparam int COST_W  = tbps_pkg::LEN_W + 3 + FRACTION_BITS,
   localparam int ENTRY_W = 2 + tbps_pkg::LEN_W + COST_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic                            csr_index,
   input  logic [tbps_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                            head_valid,
   input  logic [ENTRY_W-1:0]              head_data,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tbps_pkg::rsp_type               rsp_word,
   output logic [tbps_pkg::TOKEN_W-1:0]    bucket_depth,
   output tbps_pkg::back_status_type       status
);

   localparam int TW = tbps_pkg::TOKEN_W;
   localparam int LW = tbps_pkg::LEN_W;

   logic [tbps_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic [TW-1:0]               depth_ff, depth_in;
   logic [TW-1:0]               token_ff, token_in;
   logic                        held_valid_ff, held_valid_in;
   logic [LW-1:0]               held_len_ff, held_len_in;
   logic [COST_W-1:0]           held_cost_ff, held_cost_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tbps_pkg::rsp_type           rsp_ff, rsp_in;

   logic              op;
   logic              oversize;
   logic [LW-1:0]     len;
   logic [COST_W-1:0] cost;
   logic [TW:0]       sum;
   logic [TW-1:0]     clamped;
   logic              emit;
   logic [1:0]        st;
   logic [LW-1:0]     st_len;

   assign op       = head_data[ENTRY_W-1];
   assign oversize = head_data[ENTRY_W-2];
   assign len      = head_data[COST_W+LW-1:COST_W];
   assign cost     = head_data[COST_W-1:0];

   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rate_in  = rate_ff;
      depth_in = depth_ff;
      if (csr_write) begin
         unique case (csr_index)
            tbps_pkg::CSR_RATE:  rate_in  = csr_data[tbps_pkg::RATE_W-1:0];
            tbps_pkg::CSR_DEPTH: depth_in = csr_data[TW-1:0];
            default:             rate_in  = rate_ff;
         endcase
      end
   end

   always_comb begin
      sum     = {1'b0, token_ff} + (TW + 1)'(rate_ff);
      clamped = (sum > {1'b0, depth_ff}) ? depth_ff : sum[TW-1:0];

      token_in      = token_ff;
      held_valid_in = held_valid_ff;
      held_len_in   = held_len_ff;
      held_cost_in  = held_cost_ff;
      emit          = 1'b0;
      st            = tbps_pkg::ST_RELEASED;
      st_len        = len;

      if (pop) begin
         if (op == tbps_pkg::OP_TICK) begin
            token_in = clamped;
            st_len   = held_len_ff;
            if (held_valid_ff) begin
               if (TW'(held_cost_ff) > depth_ff) begin
                  held_valid_in = 1'b0;
                  emit          = 1'b1;
                  st            = tbps_pkg::ST_DROPPED;
               end else if (TW'(held_cost_ff) <= clamped) begin
                  token_in      = clamped - TW'(held_cost_ff);
                  held_valid_in = 1'b0;
                  emit          = 1'b1;
                  st            = tbps_pkg::ST_RELEASED;
               end
            end
         end else begin
            emit = 1'b1;
            if (held_valid_ff) begin
               st = tbps_pkg::ST_BUSY;
            end else if (oversize) begin
               st = tbps_pkg::ST_DROPPED;
            end else if (TW'(cost) <= token_ff) begin
               token_in = token_ff - TW'(cost);
               st       = tbps_pkg::ST_RELEASED;
            end else begin
               held_valid_in = 1'b1;
               held_len_in   = len;
               held_cost_in  = cost;
               st            = tbps_pkg::ST_HELD;
            end
         end
      end

      rsp_in = rsp_ff;
      if (pop) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_in = '{status: st, packet_length_out: st_len, tokens_left: token_in};
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff       <= tbps_pkg::RATE_RESET;
         depth_ff      <= tbps_pkg::DEPTH_RESET;
         token_ff      <= '0;
         held_valid_ff <= 1'b0;
         held_len_ff   <= '0;
         held_cost_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rate_ff       <= rate_in;
         depth_ff      <= depth_in;
         token_ff      <= token_in;
         held_valid_ff <= held_valid_in;
         held_len_ff   <= held_len_in;
         held_cost_ff  <= held_cost_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_ff;
   assign bucket_depth = depth_ff;
   assign status       = '{held_valid: held_valid_ff, emit: pop && emit};

endmodule

// File: test/token_bucket_packet_shaper_test.sv
// Self-checking bench of the token bucket packet shaper: a directed table, then random phases.
// Depends on tbps_pkg and token_bucket_packet_shaper; every result word is checked
// against a typed table result or a shadow token count kept in this file.
module token_bucket_packet_shaper_test;
   timeunit 1ns;
   timeprecision 1ps;

   // A byte costs 8 bits, each bit 2^FRACTION_BITS token units.
   localparam int COST_SHIFT      = 3 + tbps_pkg::FRACTION_BITS_DEFAULT;
   // Queue slot plus result register, with margin: cycles to let a tick leave the block.
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int MAX_GAP         = 12;
   localparam int PHASE_COUNT     = 10;

   localparam int LW = tbps_pkg::LEN_W;
   localparam int TW = tbps_pkg::TOKEN_W;
   localparam int RW = tbps_pkg::RATE_W;
   localparam int DW = tbps_pkg::CSR_DATA_W;

   typedef enum bit {ROW_WORD, ROW_REG} row_kind_type;

   // One row of the directed table: either a word or a register write.
   // typed rows carry their expected result in place of the shadow's; all advance the shadow.
   typedef struct {
      row_kind_type      kind;
      tbps_pkg::req_type word;
      logic              reg_index;
      logic [DW-1:0]     reg_value;
      bit                typed;
      bit                typed_has;
      tbps_pkg::rsp_type typed_rsp;
   } stim_row_type;

   typedef struct {
      logic [RW-1:0] rate;
      logic [TW-1:0] depth;
      int            words;
      int            tick_pct;
   } shaper_setting_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   tbps_pkg::req_type req_word  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   tbps_pkg::rsp_type rsp_word;
   logic              csr_write = 1'b0;
   logic              csr_index = 1'b0;
   logic [DW-1:0]     csr_data  = '0;

   // Shadow of the shaper: registers, token count and the held packet.
   logic [RW-1:0] shadow_rate     = tbps_pkg::RATE_RESET;
   logic [TW-1:0] shadow_depth    = tbps_pkg::DEPTH_RESET;
   logic [TW-1:0] shadow_tokens   = '0;
   logic          shadow_held     = 1'b0;
   logic [LW-1:0] shadow_held_len = '0;

   // Results still owed by the block, oldest first.
   tbps_pkg::rsp_type awaited_results[$];

   int send_idle_pct    = 38;
   int rcv_idle_pct     = 85;
   bit lull             = 1'b0;
   bit hold_off_pending = 1'b0;
   bit holding_off      = 1'b0;

   int mismatches   = 0;
   int words_sent   = 0;
   int results_seen = 0;
   int reg_writes   = 0;
   int quiet_cycles = 0;
   int status_seen[4];

   token_bucket_packet_shaper u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advance the shadow by one word; return whether the word yields a result.
   // Sums are formed in 64 bits so a full rate on a full count cannot wrap.
   function automatic bit shape_word(input tbps_pkg::req_type w, output tbps_pkg::rsp_type r);
      logic [63:0] sum;
      logic [63:0] cost;
      r = '0;
      if (w.operation == tbps_pkg::OP_TICK) begin
         sum = 64'(shadow_tokens) + 64'(shadow_rate);
         shadow_tokens = (sum > 64'(shadow_depth)) ? shadow_depth : sum[TW-1:0];
         if (!shadow_held) return 1'b0;
         cost = 64'(shadow_held_len) << COST_SHIFT;
         // Depth lowered under a held packet: drop it, it could never fit.
         if (cost > 64'(shadow_depth)) begin
            shadow_held = 1'b0;
            r = '{tbps_pkg::ST_DROPPED, shadow_held_len, shadow_tokens};
            return 1'b1;
         end
         if (cost > 64'(shadow_tokens)) return 1'b0;
         shadow_tokens = shadow_tokens - cost[TW-1:0];
         shadow_held = 1'b0;
         r = '{tbps_pkg::ST_RELEASED, shadow_held_len, shadow_tokens};
         return 1'b1;
      end
      // Packet while another is held: refuse, leave hold and tokens alone.
      if (shadow_held) begin
         r = '{tbps_pkg::ST_BUSY, w.packet_length, shadow_tokens};
         return 1'b1;
      end
      // Compare against the count as it stands, unclamped until the next tick.
      cost = 64'(w.packet_length) << COST_SHIFT;
      if (cost > 64'(shadow_depth)) begin
         r = '{tbps_pkg::ST_DROPPED, w.packet_length, shadow_tokens};
         return 1'b1;
      end
      if (cost <= 64'(shadow_tokens)) begin
         shadow_tokens = shadow_tokens - cost[TW-1:0];
         r = '{tbps_pkg::ST_RELEASED, w.packet_length, shadow_tokens};
         return 1'b1;
      end
      shadow_held     = 1'b1;
      shadow_held_len = w.packet_length;
      r = '{tbps_pkg::ST_HELD, w.packet_length, shadow_tokens};
      return 1'b1;
   endfunction

   function automatic stim_row_type word_row(input logic op, input logic [LW-1:0] len);
      stim_row_type row;
      row.kind               = ROW_WORD;
      row.word.operation     = op;
      row.word.packet_length = len;
      row.reg_index          = tbps_pkg::CSR_RATE;
      row.reg_value          = '0;
      row.typed              = 1'b0;
      row.typed_has          = 1'b0;
      row.typed_rsp          = '0;
      return row;
   endfunction

   function automatic stim_row_type known_row(input logic op, input logic [LW-1:0] len,
                                              input bit has, input logic [1:0] st,
                                              input logic [LW-1:0] len_out,
                                              input logic [TW-1:0] tokens);
      stim_row_type row;
      row           = word_row(op, len);
      row.typed     = 1'b1;
      row.typed_has = has;
      row.typed_rsp = '{st, len_out, tokens};
      return row;
   endfunction

   function automatic stim_row_type reg_row(input logic idx, input logic [DW-1:0] value);
      stim_row_type row;
      row           = word_row(tbps_pkg::OP_TICK, '0);
      row.kind      = ROW_REG;
      row.reg_index = idx;
      row.reg_value = value;
      return row;
   endfunction

   task automatic report_mismatch(input string what, input logic [TW-1:0] got,
                                  input logic [TW-1:0] want);
      if (mismatches < 40)
         $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Offer one word after a random gap, hold it until taken, then log what it owes.
   // valid stays high after a handshake so back-to-back words go out without it dropping.
   task automatic offer_word(input tbps_pkg::req_type w, input bit typed, input bit typed_has,
                             input tbps_pkg::rsp_type typed_rsp);
      tbps_pkg::rsp_type r;
      bit                has;
      int                gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      has = shape_word(w, r);
      if (typed) begin
         has = typed_has;
         r   = typed_rsp;
      end
      if (has) awaited_results.push_back(r);
      words_sent++;
   endtask

   // Bring the block to rest: stop offering, unstall the receiver, wait for every
   // owed result, then give any trailing ticks time to leave the queue.
   task automatic settle();
      req_valid <= 1'b0;
      lull = 1'b1;
      do @(posedge clock);
      while (awaited_results.size() != 0 || holding_off || hold_off_pending);
      repeat (DRAIN_CYCLES) @(posedge clock);
      lull = 1'b0;
   endtask

   // Write one register; the caller drops csr_write after the last write of a group.
   task automatic program_reg(input logic idx, input logic [DW-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      if (idx == tbps_pkg::CSR_RATE) shadow_rate = value[RW-1:0];
      else shadow_depth = value[TW-1:0];
      reg_writes++;
   endtask

   // Receiver: random stalls, or a long hold-off on request so the queue fills
   // and the block pushes back on the sender.
   initial begin : receiver_side
      int stretch;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            holding_off      = 1'b1;
            for (stretch = 0; stretch < HOLD_OFF_CYCLES; stretch++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
            holding_off = 1'b0;
         end
         rsp_stall <= !lull && ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Check each result word against the oldest owed one, field by field.
   always @(posedge clock) begin : check_results
      tbps_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         status_seen[rsp_word.status]++;
         if (awaited_results.size() == 0) begin
            report_mismatch("result word with none owed, length",
                            TW'(rsp_word.packet_length_out), '0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_word.status !== want.status)
               report_mismatch("status", TW'(rsp_word.status), TW'(want.status));
            if (rsp_word.packet_length_out !== want.packet_length_out)
               report_mismatch("packet length", TW'(rsp_word.packet_length_out),
                               TW'(want.packet_length_out));
            if (rsp_word.tokens_left !== want.tokens_left)
               report_mismatch("tokens left", rsp_word.tokens_left, want.tokens_left);
         end
      end
   end

   // Watchdog: end the run when nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type       plan[$];
      shaper_setting_type settings[PHASE_COUNT];
      tbps_pkg::req_type  w;
      logic [RW-1:0]      rnd_rate;
      int                 p;
      int                 n;
      int                 span;

      // Directed table, starting from reset values: rate 1 bit per tick, deep bucket.
      plan.push_back(known_row(tbps_pkg::OP_TICK, 16'h0000, 1'b0, tbps_pkg::ST_RELEASED,
                               16'd0, 40'd0));
      // Zero length costs nothing: release at once.
      plan.push_back(known_row(tbps_pkg::OP_PACKET, 16'h0000, 1'b1, tbps_pkg::ST_RELEASED,
                               16'd0, 40'd256));
      plan.push_back(known_row(tbps_pkg::OP_PACKET, 16'h0001, 1'b1, tbps_pkg::ST_HELD,
                               16'd1, 40'd256));
      // Packet during a hold: refuse, whatever its size.
      plan.push_back(known_row(tbps_pkg::OP_PACKET, 16'hFFFF, 1'b1, tbps_pkg::ST_BUSY,
                               16'hFFFF, 40'd256));
      plan.push_back(reg_row(tbps_pkg::CSR_RATE, 40'd2048));
      // Tick brings enough for the held byte; tick length field is ignored.
      plan.push_back(known_row(tbps_pkg::OP_TICK, 16'hABCD, 1'b1, tbps_pkg::ST_RELEASED,
                               16'd1, 40'd256));
      plan.push_back(known_row(tbps_pkg::OP_PACKET, 16'hFFFF, 1'b1, tbps_pkg::ST_HELD,
                               16'hFFFF, 40'd256));
      // Depth lowered under the held packet: drop it on the next tick.
      plan.push_back(reg_row(tbps_pkg::CSR_DEPTH, 40'd4096));
      plan.push_back(known_row(tbps_pkg::OP_TICK, 16'h5555, 1'b1, tbps_pkg::ST_DROPPED,
                               16'hFFFF, 40'd2304));
      // Cost exactly equal to depth fits once the count clamps at depth.
      plan.push_back(known_row(tbps_pkg::OP_PACKET, 16'h0002, 1'b1, tbps_pkg::ST_HELD,
                               16'd2, 40'd2304));
      plan.push_back(known_row(tbps_pkg::OP_TICK, 16'h0000, 1'b1, tbps_pkg::ST_RELEASED,
                               16'd2, 40'd0));
      // Full rate into a full-width bucket.
      plan.push_back(reg_row(tbps_pkg::CSR_RATE, 40'hFF_FFFF_FFFF));
      plan.push_back(reg_row(tbps_pkg::CSR_DEPTH, 40'hFF_FFFF_FFFF));
      plan.push_back(known_row(tbps_pkg::OP_TICK, 16'hFFFF, 1'b0, tbps_pkg::ST_RELEASED,
                               16'd0, 40'd0));
      plan.push_back(word_row(tbps_pkg::OP_PACKET, 16'hFFFF));
      // Depth zero under a large count: oversize drops keep the tokens, zero length
      // passes against the unclamped count, and the next tick clamps to zero.
      plan.push_back(reg_row(tbps_pkg::CSR_DEPTH, 40'd0));
      plan.push_back(word_row(tbps_pkg::OP_PACKET, 16'h0001));
      plan.push_back(word_row(tbps_pkg::OP_PACKET, 16'h0000));
      plan.push_back(known_row(tbps_pkg::OP_TICK, 16'h0000, 1'b0, tbps_pkg::ST_RELEASED,
                               16'd0, 40'd0));
      plan.push_back(known_row(tbps_pkg::OP_PACKET, 16'h0000, 1'b1, tbps_pkg::ST_RELEASED,
                               16'd0, 40'd0));
      // No refill: a held packet stays held and a zero length packet is refused too.
      plan.push_back(reg_row(tbps_pkg::CSR_RATE, 40'd0));
      plan.push_back(reg_row(tbps_pkg::CSR_DEPTH, 40'(tbps_pkg::DEPTH_RESET)));
      plan.push_back(known_row(tbps_pkg::OP_PACKET, 16'h0003, 1'b1, tbps_pkg::ST_HELD,
                               16'd3, 40'd0));
      plan.push_back(known_row(tbps_pkg::OP_TICK, 16'h0000, 1'b0, tbps_pkg::ST_RELEASED,
                               16'd0, 40'd0));
      plan.push_back(known_row(tbps_pkg::OP_PACKET, 16'h0000, 1'b1, tbps_pkg::ST_BUSY,
                               16'd0, 40'd0));
      plan.push_back(known_row(tbps_pkg::OP_PACKET, 16'hFFFF, 1'b1, tbps_pkg::ST_BUSY,
                               16'hFFFF, 40'd0));

      // Random phases: rate, depth, word count, share of ticks.
      rnd_rate     = 32'($urandom_range(1, 1 << 20));
      settings[0]  = '{tbps_pkg::RATE_RESET, tbps_pkg::DEPTH_RESET, 120, 50};
      settings[1]  = '{32'd12288, 40'd81920, 140, 50};
      settings[2]  = '{32'd0, 40'd204800, 60, 40};
      // Mostly ticks, so the count climbs to the top of a full-width bucket.
      settings[3]  = '{32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 360, 90};
      settings[4]  = '{32'hFFFF_FFFF, 40'd0, 60, 50};
      settings[5]  = '{32'($urandom), {8'($urandom_range(255)), 32'($urandom)}, 120, 50};
      // Depth equal to the cost of the longest packet.
      settings[6]  = '{32'd100000, 40'd134215680, 120, 50};
      settings[7]  = '{32'd3000, 40'd20000, 100, 50};
      settings[8]  = '{rnd_rate, 40'(rnd_rate) * 40'($urandom_range(2, 40)), 140, 50};
      settings[9]  = '{32'd614400, 40'd4096000, 100, 50};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_REG) begin
            settle();
            program_reg(plan[i].reg_index, plan[i].reg_value);
            csr_write <= 1'b0;
         end else begin
            offer_word(plan[i].word, plan[i].typed, plan[i].typed_has, plan[i].typed_rsp);
         end
      end

      for (p = 0; p < PHASE_COUNT; p++) begin
         settle();
         program_reg(tbps_pkg::CSR_RATE, 40'(settings[p].rate));
         program_reg(tbps_pkg::CSR_DEPTH, settings[p].depth);
         csr_write <= 1'b0;
         // Idle sender lightly and receiver heavily, then swap, then run flat out.
         if (p < 4) begin
            send_idle_pct = 38;
            rcv_idle_pct  = 85;
         end else if (p < 7) begin
            send_idle_pct = 85;
            rcv_idle_pct  = 38;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         // Keep most lengths near a few ticks' worth of refill so that holds
         // resolve into releases rather than sitting until refused.
         span = int'(settings[p].rate >> 11) * 3 + 3;
         if (span > 65535) span = 65535;
         for (n = 0; n < settings[p].words; n++) begin
            if ((p == 1 || p == 8) && n == 40) hold_off_pending = 1'b1;
            w.packet_length = LW'($urandom);
            if ($urandom_range(99) < settings[p].tick_pct) begin
               w.operation = tbps_pkg::OP_TICK;
            end else begin
               w.operation = tbps_pkg::OP_PACKET;
               case ($urandom_range(9))
                  0: w.packet_length = '0;
                  1: w.packet_length = '1;
                  2, 3: w.packet_length = LW'($urandom);
                  default: w.packet_length = LW'($urandom_range(span));
               endcase
            end
            offer_word(w, 1'b0, 1'b0, '0);
         end
      end

      settle();

      $display("Shaper run: %0d words, %0d register writes, %0d results checked.",
               words_sent, reg_writes, results_seen);
      $display("Results by status: released %0d, held %0d, dropped %0d, refused %0d.",
               status_seen[tbps_pkg::ST_RELEASED], status_seen[tbps_pkg::ST_HELD],
               status_seen[tbps_pkg::ST_DROPPED], status_seen[tbps_pkg::ST_BUSY]);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
